/* rtl/core/koc_pkg.sv */
// Package for the keyword occurrence counter: sizes, command codes, states and keyword table.
package koc_pkg;

    localparam int NUM_KEYWORDS = 9;
    localparam int COUNT_WIDTH  = 32;
    localparam int KW_SLOTS     = 9;
    localparam int KW_MAXLEN    = 8;
    localparam int PROG_W       = $clog2(KW_MAXLEN);
    localparam int LEN_W        = $clog2(KW_MAXLEN + 1);
    localparam int IDX_W        = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int KWIDX_W      = 4;
    localparam int OCC_W        = 32;
    localparam logic [7:0] NEWLINE = 8'h0a;

    typedef enum logic [1:0] {
        CMD_TEXT   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    localparam logic [0:KW_SLOTS-1][0:KW_MAXLEN-1][7:0] KW_TEXT = '{
        '{"m", "a", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"#", "i", "n", "c", "l", "u", "d", "e"},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
        '{"s", "t", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [0:KW_SLOTS-1][LEN_W-1:0] KW_LEN = '{
        LEN_W'(4), LEN_W'(3), LEN_W'(8), LEN_W'(5), LEN_W'(6),
        LEN_W'(6), LEN_W'(5), LEN_W'(3), LEN_W'(2)
    };

endpackage

/* rtl/core/keyword_occurrence_counter.sv */
// Keyword occurrence counter: nine parallel keyword matchers with saturating counts.
// A text byte is taken every cycle while no report stalls the input; matchers and counts
// update from its input register. A report stalls the input from its acceptance until its last
// item is loaded: it starts from its registered command, finds the most frequent keyword
// through one comparator, then loads one item per cycle while the output is not stalled.
// Synchronous reset clears all counts, matchers, valid flags and the report sequencer.
module keyword_occurrence_counter
    import koc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_command,
    input  logic [7:0]             i_text_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [KWIDX_W-1:0]     o_keyword_index,
    output logic [OCC_W-1:0]       o_occurrences,
    output logic                   o_is_most_frequent,
    output logic                   o_last_of_report
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYWORDS - 1);

    logic                    r_in_vld;
    logic [1:0]              r_cmd;
    logic [7:0]              r_byte;
    logic                    r_pend, n_pend;
    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [IDX_W-1:0]        r_best, n_best;
    logic [COUNT_WIDTH-1:0]  r_best_cnt, n_best_cnt;
    logic [PROG_W-1:0]       r_prog [NUM_KEYWORDS];
    logic [PROG_W-1:0]       n_prog [NUM_KEYWORDS];
    logic [COUNT_WIDTH-1:0]  r_cnt [NUM_KEYWORDS];
    logic [COUNT_WIDTH-1:0]  n_cnt [NUM_KEYWORDS];
    logic                    r_out_vld, n_out_vld;
    logic [KWIDX_W-1:0]      r_out_idx, n_out_idx;
    logic [OCC_W-1:0]        r_out_occ, n_out_occ;
    logic                    r_out_best, n_out_best;
    logic                    r_out_last, n_out_last;

    logic                              in_acc;
    logic                              out_free;
    logic [COUNT_WIDTH-1:0]            cnt_sel;
    logic [COUNT_WIDTH+OCC_W-1:0]      cnt_ext;
    logic [OCC_W-1:0]                  occ_sat;

    assign in_acc     = i_in_valid && !r_pend;
    assign o_in_stall = r_pend;
    assign out_free   = !r_out_vld || !i_out_stall;

    assign cnt_sel = r_cnt[r_idx];
    assign cnt_ext = {OCC_W'(0), cnt_sel};
    assign occ_sat = (|cnt_ext[COUNT_WIDTH+OCC_W-1:OCC_W]) ? '1 : cnt_ext[OCC_W-1:0];

    always_comb begin
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            n_prog[k] = r_prog[k];
            n_cnt[k]  = r_cnt[k];
            if (r_in_vld && r_cmd == CMD_CLEAR) begin
                n_prog[k] = '0;
                n_cnt[k]  = '0;
            end else if (r_in_vld && r_cmd == CMD_TEXT) begin
                if (r_byte == NEWLINE) begin
                    n_prog[k] = '0;
                end else if (KW_TEXT[k][r_prog[k]] == r_byte) begin
                    if (LEN_W'(r_prog[k]) + LEN_W'(1) == KW_LEN[k]) begin
                        n_prog[k] = '0;
                        if (r_cnt[k] != '1) begin
                            n_cnt[k] = r_cnt[k] + COUNT_WIDTH'(1);
                        end
                    end else begin
                        n_prog[k] = r_prog[k] + PROG_W'(1);
                    end
                end else begin
                    n_prog[k] = (KW_TEXT[k][0] == r_byte) ? PROG_W'(1) : '0;
                end
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_idx      = r_idx;
        n_best     = r_best;
        n_best_cnt = r_best_cnt;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_idx  = r_out_idx;
        n_out_occ  = r_out_occ;
        n_out_best = r_out_best;
        n_out_last = r_out_last;
        if (in_acc && i_command == CMD_REPORT) begin
            n_pend = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (r_in_vld && r_cmd == CMD_REPORT) begin
                    n_best     = '0;
                    n_best_cnt = r_cnt[0];
                    if (NUM_KEYWORDS == 1) begin
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_idx   = IDX_W'(1);
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_sel > r_best_cnt) begin
                    n_best     = r_idx;
                    n_best_cnt = cnt_sel;
                end
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_idx  = KWIDX_W'(r_idx);
                    n_out_occ  = occ_sat;
                    n_out_best = (r_idx == r_best);
                    n_out_last = (r_idx == LAST_IDX);
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                        n_pend  = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_in_vld  <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                r_prog[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_in_vld  <= in_acc;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                r_prog[k] <= n_prog[k];
                r_cnt[k]  <= n_cnt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_command;
            r_byte <= i_text_byte;
        end
        r_idx      <= n_idx;
        r_best     <= n_best;
        r_best_cnt <= n_best_cnt;
        r_out_idx  <= n_out_idx;
        r_out_occ  <= n_out_occ;
        r_out_best <= n_out_best;
        r_out_last <= n_out_last;
    end

    assign o_out_valid        = r_out_vld;
    assign o_keyword_index    = r_out_idx;
    assign o_occurrences      = r_out_occ;
    assign o_is_most_frequent = r_out_best;
    assign o_last_of_report   = r_out_last;

`ifndef ASSERT_OFF
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> r_pend)
        else $error("Report sequencer active without input stall.");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_report) |-> (o_keyword_index == KWIDX_W'(NUM_KEYWORDS - 1)))
        else $error("Last item of a report carries the wrong keyword index.");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_cmd == CMD_CLEAR) |=> (r_cnt[0] == '0 && r_prog[0] == '0))
        else $error("Clear did not reset the first count and matcher.");

    a_pend_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pend) |-> ($past(i_in_valid) && $past(i_command) == CMD_REPORT))
        else $error("Input stall raised without an accepted report item.");
`endif

endmodule
